// ===== sv/rbst_pkg.sv =====
// Shared constants and types for the ray versus box slab test.
package rbst_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int REG_W         = 21;
  localparam int COORD_W       = 32;
  localparam int DIST_W        = 31;
  // bound minus origin, sign included
  localparam int DIFF_W        = 35;

  localparam logic [REG_W-1:0] BOX_WIDTH_RST  = 21'd52429;
  localparam logic [REG_W-1:0] BOX_HEIGHT_RST = 21'd117965;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 1'b1;

  // per-transaction data that rides alongside the dividers
  typedef struct packed {
    logic [DIST_W-1:0] max_dist;
    logic              alive;
    logic [2:0]        near_zero;
    logic [2:0]        in_slab;
    logic [5:0]        q_neg;
  } side_t;

endpackage

// ===== sv/rbst_if.sv =====
// Channel interfaces for ray transactions and test results.
interface rbst_in_if
  import rbst_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic signed [COORD_W-1:0] dir_x;
  logic signed [COORD_W-1:0] dir_y;
  logic signed [COORD_W-1:0] dir_z;
  logic [DIST_W-1:0]         max_dist;
  logic signed [COORD_W-1:0] box_center_x;
  logic signed [COORD_W-1:0] box_top_y;
  logic signed [COORD_W-1:0] box_center_z;
  logic                      box_alive;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  max_dist, box_center_x, box_top_y, box_center_z, box_alive,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                max_dist, box_center_x, box_top_y, box_center_z, box_alive,
                output ready);
endinterface

interface rbst_out_if
  import rbst_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] hit_dist;

  modport source (output valid, hit, hit_dist, input ready);
  modport sink (input valid, hit, hit_dist, output ready);
endinterface

// ===== sv/rbst_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
module rbst_div
  import rbst_pkg::*;
#(
  parameter int NUM_W = 51,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [NUM_W-1:0] quo_out
);

  // num_r holds remaining dividend bits on top, quotient bits shift in below
  logic [NUM_W-1:0] num_r [0:NUM_W];
  logic [DEN_W-1:0] rem_r [0:NUM_W];
  logic [DEN_W-1:0] den_r [0:NUM_W];

  assign num_r[0] = num_in;
  assign rem_r[0] = '0;
  assign den_r[0] = den_in;

  for (genvar k = 1; k <= NUM_W; k++) begin : g_stage
    logic [DEN_W:0]   part;
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] rem_nxt;
    logic [NUM_W-1:0] num_nxt;

    always_comb begin
      part  = {rem_r[k-1], num_r[k-1][NUM_W-1]};
      trial = part - {1'b0, den_r[k-1]};
      if (trial[DEN_W]) begin
        rem_nxt = part[DEN_W-1:0];
        num_nxt = {num_r[k-1][NUM_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        num_nxt = {num_r[k-1][NUM_W-2:0], 1'b1};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= num_nxt;
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign quo_out = num_r[NUM_W];

endmodule

// ===== sv/ray_box_slab_test_top.sv =====
// Top level: ray versus axis-aligned box slab test, fully pipelined.
// Accepts one ray transaction per clock and returns one result per transaction
// in order. The pipe (Q16.16 by default) holds an input stage,
// a bound/difference stage, six parallel radix-2 dividers with one quotient bit
// per stage (FRAC_BITS + 35 stages), then sort, two min/max stages and the
// output register. The whole pipe freezes while a result waits at the output.
// box_width and box_height should be written only while the pipe is empty.
module ray_box_slab_test_top
  import rbst_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rbst_in_if.sink              in_ch,
  rbst_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0]     cfg_wdata
);

  localparam int NUM_W   = DIFF_W + FRAC_BITS;
  localparam int TW      = NUM_W + 1;
  localparam int NEAR_ZERO_LSB = ((1 << FRAC_BITS) + 9999) / 10000;
  localparam logic [COORD_W-1:0] NZ_LIM = COORD_W'(NEAR_ZERO_LSB);

  logic en;

  // ---------------- configuration
  logic [REG_W-1:0] box_width_r, box_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r  <= BOX_WIDTH_RST;
      box_height_r <= BOX_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BOX_WIDTH:  box_width_r  <= cfg_wdata;
        CFG_BOX_HEIGHT: box_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: input register
  logic                      v1_r;
  logic signed [COORD_W-1:0] org_r [0:2];
  logic signed [COORD_W-1:0] dir_r [0:2];
  logic signed [COORD_W-1:0] ctr_r [0:2];
  logic [DIST_W-1:0]         maxd1_r;
  logic                      alive1_r;

  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      org_r[0] <= in_ch.origin_x;
      org_r[1] <= in_ch.origin_y;
      org_r[2] <= in_ch.origin_z;
      dir_r[0] <= in_ch.dir_x;
      dir_r[1] <= in_ch.dir_y;
      dir_r[2] <= in_ch.dir_z;
      ctr_r[0] <= in_ch.box_center_x;
      ctr_r[1] <= in_ch.box_top_y;
      ctr_r[2] <= in_ch.box_center_z;
      maxd1_r  <= in_ch.max_dist;
      alive1_r <= in_ch.box_alive;
    end
  end

  // ---------------- stage 2: slab differences, magnitudes, flags
  logic signed [DIFF_W-1:0] half_s, height_s;
  assign half_s   = $signed({{(DIFF_W-REG_W+1){1'b0}}, box_width_r[REG_W-1:1]});
  assign height_s = $signed({{(DIFF_W-REG_W){1'b0}}, box_height_r});

  logic              vld_r  [0:NUM_W];
  side_t             side_r [0:NUM_W];
  logic [NUM_W-1:0]  num_r  [0:5];
  logic [COORD_W-1:0] den_r [0:2];
  side_t             side_nxt;
  logic [NUM_W-1:0]  num_nxt [0:5];
  logic [COORD_W-1:0] den_nxt [0:2];

  always_comb begin
    logic signed [DIFF_W-1:0] c_e, o_e, d_lo, d_hi;
    logic [DIFF_W-1:0]        m_lo, m_hi;
    side_nxt.max_dist = maxd1_r;
    side_nxt.alive    = alive1_r;
    for (int a = 0; a < 3; a++) begin
      c_e = DIFF_W'(ctr_r[a]);
      o_e = DIFF_W'(org_r[a]);
      if (a == 1) begin
        d_lo = c_e - height_s - o_e;
        d_hi = c_e - o_e;
      end else begin
        d_lo = c_e - half_s - o_e;
        d_hi = c_e + half_s - o_e;
      end
      m_lo = d_lo[DIFF_W-1] ? DIFF_W'(-d_lo) : DIFF_W'(d_lo);
      m_hi = d_hi[DIFF_W-1] ? DIFF_W'(-d_hi) : DIFF_W'(d_hi);
      num_nxt[2*a]   = {m_lo, {FRAC_BITS{1'b0}}};
      num_nxt[2*a+1] = {m_hi, {FRAC_BITS{1'b0}}};
      den_nxt[a] = dir_r[a][COORD_W-1] ? COORD_W'(-dir_r[a]) : COORD_W'(dir_r[a]);
      side_nxt.near_zero[a] = (den_nxt[a] < NZ_LIM);
      // origin within the slab, bounds inclusive
      side_nxt.in_slab[a] = !(d_lo > 0) && !d_hi[DIFF_W-1];
      side_nxt.q_neg[2*a]   = d_lo[DIFF_W-1] ^ dir_r[a][COORD_W-1];
      side_nxt.q_neg[2*a+1] = d_hi[DIFF_W-1] ^ dir_r[a][COORD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      num_r     <= num_nxt;
      den_r     <= den_nxt;
    end
  end

  // ---------------- divider stages
  logic [NUM_W-1:0] quo [0:5];

  for (genvar d = 0; d < 6; d++) begin : g_div
    rbst_div #(.NUM_W(NUM_W), .DEN_W(COORD_W)) u_div (
      .clk     (clk),
      .en      (en),
      .num_in  (num_r[d]),
      .den_in  (den_r[d/2]),
      .quo_out (quo[d])
    );
  end

  for (genvar k = 1; k <= NUM_W; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else if (en) vld_r[k] <= vld_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) side_r[k] <= side_r[k-1];
    end
  end

  // ---------------- stage 3: sign, sort, near-zero masking
  side_t sd;
  assign sd = side_r[NUM_W];

  logic signed [TW-1:0] maxd_s;
  assign maxd_s = $signed({{(TW-DIST_W){1'b0}}, sd.max_dist});

  logic                 v3_r;
  logic signed [TW-1:0] lo3_r [0:2];
  logic signed [TW-1:0] hi3_r [0:2];
  logic                 ok3_r;
  logic signed [TW-1:0] maxd3_r;
  logic signed [TW-1:0] lo3_nxt [0:2];
  logic signed [TW-1:0] hi3_nxt [0:2];
  logic                 ok3_nxt;

  always_comb begin
    logic signed [TW-1:0] t1, t2;
    ok3_nxt = sd.alive;
    for (int a = 0; a < 3; a++) begin
      t1 = sd.q_neg[2*a]   ? -$signed({1'b0, quo[2*a]})   : $signed({1'b0, quo[2*a]});
      t2 = sd.q_neg[2*a+1] ? -$signed({1'b0, quo[2*a+1]}) : $signed({1'b0, quo[2*a+1]});
      if (sd.near_zero[a]) begin
        // axis does not narrow the interval
        lo3_nxt[a] = '0;
        hi3_nxt[a] = maxd_s;
        ok3_nxt    = ok3_nxt & sd.in_slab[a];
      end else if (t1 > t2) begin
        lo3_nxt[a] = t2;
        hi3_nxt[a] = t1;
      end else begin
        lo3_nxt[a] = t1;
        hi3_nxt[a] = t2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= vld_r[NUM_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo3_r   <= lo3_nxt;
      hi3_r   <= hi3_nxt;
      ok3_r   <= ok3_nxt;
      maxd3_r <= maxd_s;
    end
  end

  // ---------------- stage 4: pairwise max/min
  logic                 v4_r, ok4_r;
  logic signed [TW-1:0] lo4a_r, lo4b_r, hi4a_r, hi4b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok4_r  <= ok3_r;
      lo4a_r <= (lo3_r[0] > lo3_r[1]) ? lo3_r[0] : lo3_r[1];
      lo4b_r <= (lo3_r[2] > 0) ? lo3_r[2] : '0;
      hi4a_r <= (hi3_r[0] < hi3_r[1]) ? hi3_r[0] : hi3_r[1];
      hi4b_r <= (hi3_r[2] < maxd3_r) ? hi3_r[2] : maxd3_r;
    end
  end

  // ---------------- stage 5: final interval
  logic                 v5_r, ok5_r;
  logic signed [TW-1:0] lo5_r, hi5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok5_r <= ok4_r;
      lo5_r <= (lo4a_r > lo4b_r) ? lo4a_r : lo4b_r;
      hi5_r <= (hi4a_r < hi4b_r) ? hi4a_r : hi4b_r;
    end
  end

  // ---------------- stage 6: output register
  logic              out_valid_r, hit_r;
  logic [DIST_W-1:0] hit_dist_r;
  logic              hit_nxt;

  assign en      = !out_valid_r || out_ch.ready;
  assign hit_nxt = ok5_r && (lo5_r <= hi5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r      <= hit_nxt;
      hit_dist_r <= hit_nxt ? lo5_r[DIST_W-1:0] : '0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.hit      = hit_r;
  assign out_ch.hit_dist = hit_dist_r;

endmodule

// ===== sv/rbst_checker.sv =====
// Port-level checker for the slab test top level, attached by bind.
module rbst_checker
  import rbst_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_hit,
  input logic [DIST_W-1:0] out_hit_dist
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_hit_dist))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_dist == '0)
    else $error("miss with nonzero distance");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ray_box_slab_test_top rbst_checker u_rbst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_hit      (out_ch.hit),
  .out_hit_dist (out_ch.hit_dist)
);
